FILE: rtl/core/nec_tx_pkg.sv
`timescale 1ns / 1ps

package nec_tx_pkg;

  // Frame geometry
  localparam int FRAME_BITS  = 32;
  localparam int BIT_POS_W   = 6;
  localparam int BYTE_W      = 8;

  // Timing register widths
  localparam int DUR_W       = 16;
  localparam int GAP_TICKS_W = 20;
  localparam int CFG_DATA_W  = GAP_TICKS_W;
  localparam int CFG_IDX_W   = 3;

  // Default width of the frame-to-frame gap counter
  localparam int GAP_COUNTER_BITS_DEF = 20;

  // Register map
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_MARK   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HDR_SPACE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_MARK   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ONE_SPACE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_ZERO_SPACE = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_STOP_MARK  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd6;

  // Register reset values (standard NEC timing in microseconds)
  localparam logic [DUR_W-1:0]       HDR_MARK_RST   = 16'd9000;
  localparam logic [DUR_W-1:0]       HDR_SPACE_RST  = 16'd4500;
  localparam logic [DUR_W-1:0]       BIT_MARK_RST   = 16'd560;
  localparam logic [DUR_W-1:0]       ONE_SPACE_RST  = 16'd1690;
  localparam logic [DUR_W-1:0]       ZERO_SPACE_RST = 16'd560;
  localparam logic [DUR_W-1:0]       STOP_MARK_RST  = 16'd560;
  localparam logic [GAP_TICKS_W-1:0] GAP_RST        = 20'd108000;

  typedef struct packed {
    logic [DUR_W-1:0]       hdr_mark;
    logic [DUR_W-1:0]       hdr_space;
    logic [DUR_W-1:0]       bit_mark;
    logic [DUR_W-1:0]       one_space;
    logic [DUR_W-1:0]       zero_space;
    logic [DUR_W-1:0]       stop_mark;
    logic [GAP_TICKS_W-1:0] gap;
  } nec_tx_cfg_t;

  typedef struct packed {
    logic mark;
    logic tx_busy;
    logic sequence_done;
    logic frame_start;
  } nec_tx_res_t;

  // Data word: address, ~address, command, ~command, low byte first
  function automatic logic [FRAME_BITS-1:0] build_word(input logic [BYTE_W-1:0] a,
                                                       input logic [BYTE_W-1:0] c);
    return {~c, c, ~a, a};
  endfunction

endpackage

FILE: rtl/core/nec_tx_engine.sv
`timescale 1ns / 1ps

module nec_tx_engine #(
  parameter int GAP_COUNTER_BITS = nec_tx_pkg::GAP_COUNTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              step_en,
  input  logic                              in_kind,
  input  logic [nec_tx_pkg::BYTE_W-1:0]     in_addr,
  input  logic [nec_tx_pkg::BYTE_W-1:0]     in_cmd,
  input  logic [nec_tx_pkg::BYTE_W-1:0]     in_repeat_total,
  input  nec_tx_pkg::nec_tx_cfg_t           cfg,
  output nec_tx_pkg::nec_tx_res_t           res
);
  import nec_tx_pkg::*;

  localparam int GW    = GAP_COUNTER_BITS;
  localparam int CMP_W = (GW > GAP_TICKS_W) ? GW : GAP_TICKS_W;
  localparam logic [GW-1:0] GAP_MAX = {GW{1'b1}};

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_HDR_MARK  = 3'd1,
    PH_HDR_SPACE = 3'd2,
    PH_BIT_MARK  = 3'd3,
    PH_BIT_SPACE = 3'd4,
    PH_STOP      = 3'd5
  } phase_t;

  phase_t                  phase_r, phase_nxt;
  logic [FRAME_BITS-1:0]   shift_r, shift_nxt;
  logic [BIT_POS_W-1:0]    bitpos_r, bitpos_nxt;
  logic [DUR_W-1:0]        cd_r, cd_nxt;
  logic [GW-1:0]           gap_r, gap_nxt;
  logic [BYTE_W-1:0]       seq_addr_r, seq_addr_nxt;
  logic [BYTE_W-1:0]       seq_cmd_r, seq_cmd_nxt;
  logic [BYTE_W-1:0]       seq_total_r, seq_total_nxt;
  logic [BYTE_W-1:0]       sent_r, sent_nxt;
  logic                    active_r, active_nxt;
  nec_tx_res_t             res_r, res_nxt;

  // Next state for one request: either a tick or a start request
  always_comb begin
    logic gap_ok;
    logic started;

    phase_nxt     = phase_r;
    shift_nxt     = shift_r;
    bitpos_nxt    = bitpos_r;
    cd_nxt        = cd_r;
    gap_nxt       = gap_r;
    seq_addr_nxt  = seq_addr_r;
    seq_cmd_nxt   = seq_cmd_r;
    seq_total_nxt = seq_total_r;
    sent_nxt      = sent_r;
    active_nxt    = active_r;
    started       = 1'b0;

    if (in_kind) begin
      // start request: overwrite the sequence, skip the gap wait
      seq_addr_nxt  = in_addr;
      seq_cmd_nxt   = in_cmd;
      seq_total_nxt = in_repeat_total;
      sent_nxt      = '0;
      active_nxt    = 1'b1;
      gap_nxt       = GAP_MAX;
    end else begin
      // tick: gap counter saturates, phase timer counts down
      if (gap_r != GAP_MAX) gap_nxt = gap_r + 1'b1;
      if (phase_r != PH_IDLE) begin
        if (cd_r <= DUR_W'(1)) begin
          case (phase_r)
            PH_HDR_MARK: begin
              phase_nxt = PH_HDR_SPACE;
              cd_nxt    = cfg.hdr_space;
            end
            PH_HDR_SPACE: begin
              phase_nxt  = PH_BIT_MARK;
              bitpos_nxt = '0;
              cd_nxt     = cfg.bit_mark;
            end
            PH_BIT_MARK: begin
              phase_nxt = PH_BIT_SPACE;
              cd_nxt    = shift_r[0] ? cfg.one_space : cfg.zero_space;
            end
            PH_BIT_SPACE: begin
              shift_nxt  = shift_r >> 1;
              bitpos_nxt = bitpos_r + 1'b1;
              if (bitpos_nxt < BIT_POS_W'(FRAME_BITS)) begin
                phase_nxt = PH_BIT_MARK;
                cd_nxt    = cfg.bit_mark;
              end else begin
                phase_nxt = PH_STOP;
                cd_nxt    = cfg.stop_mark;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
              cd_nxt    = '0;
            end
          endcase
        end else begin
          cd_nxt = cd_r - 1'b1;
        end
      end
    end

    // sequence control: end it, or launch the next frame
    gap_ok = (CMP_W'(gap_nxt) >= CMP_W'(cfg.gap)) || (gap_nxt == GAP_MAX);
    if (active_nxt) begin
      if (sent_nxt >= seq_total_nxt) begin
        active_nxt = 1'b0;
      end else if (phase_nxt == PH_IDLE && gap_ok) begin
        shift_nxt  = build_word(seq_addr_nxt, seq_cmd_nxt);
        bitpos_nxt = '0;
        phase_nxt  = PH_HDR_MARK;
        cd_nxt     = cfg.hdr_mark;
        gap_nxt    = '0;
        sent_nxt   = sent_nxt + 1'b1;
        started    = 1'b1;
      end
    end

    res_nxt.mark          = (phase_nxt == PH_HDR_MARK) || (phase_nxt == PH_BIT_MARK) ||
                            (phase_nxt == PH_STOP);
    res_nxt.tx_busy       = (phase_nxt != PH_IDLE);
    res_nxt.sequence_done = ~active_nxt;
    res_nxt.frame_start   = started;
  end

  // State and result register, advanced once per accepted request
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      shift_r     <= '0;
      bitpos_r    <= '0;
      cd_r        <= '0;
      gap_r       <= GAP_MAX;
      seq_addr_r  <= '0;
      seq_cmd_r   <= '0;
      seq_total_r <= '0;
      sent_r      <= '0;
      active_r    <= 1'b0;
      res_r       <= '0;
    end else if (step_en) begin
      phase_r     <= phase_nxt;
      shift_r     <= shift_nxt;
      bitpos_r    <= bitpos_nxt;
      cd_r        <= cd_nxt;
      gap_r       <= gap_nxt;
      seq_addr_r  <= seq_addr_nxt;
      seq_cmd_r   <= seq_cmd_nxt;
      seq_total_r <= seq_total_nxt;
      sent_r      <= sent_nxt;
      active_r    <= active_nxt;
      res_r       <= res_nxt;
    end
  end

  assign res = res_r;

  // A frame opens in header mark with the gap counter restarted
  a_start_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.frame_start |-> (phase_r == PH_HDR_MARK) && (gap_r == '0) && res_r.mark)
    else $error("frame start without header mark or gap restart");

  // Marks only occur inside a frame
  a_mark_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_r.mark |-> res_r.tx_busy)
    else $error("mark outside a frame");

  // Never more frames than requested
  a_sent_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sent_r <= seq_total_r)
    else $error("frame count exceeds repeat total");

  // Idle transmitter holds a cleared phase timer
  a_idle_cd: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (cd_r == '0))
    else $error("phase timer running while idle");

endmodule

FILE: rtl/core/nec_ir_frame_transmitter.sv
`timescale 1ns / 1ps
// Output: the result for a request is on out_* in the cycle after acceptance.
// Throughput: one request per cycle unless in_stall; the state update (phase
//   timer, gap counter, frame launch) is one combinational step into registers.
// Reset: synchronous, active low; timing registers return to NEC defaults, the
//   transmitter goes idle with no sequence and a saturated gap counter.
module nec_ir_frame_transmitter #(
  parameter int GAP_COUNTER_BITS = nec_tx_pkg::GAP_COUNTER_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_kind,
  input  logic [nec_tx_pkg::BYTE_W-1:0]     in_addr,
  input  logic [nec_tx_pkg::BYTE_W-1:0]     in_cmd,
  input  logic [nec_tx_pkg::BYTE_W-1:0]     in_repeat_total,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_mark,
  output logic                              out_tx_busy,
  output logic                              out_sequence_done,
  output logic                              out_frame_start,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [nec_tx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [nec_tx_pkg::CFG_DATA_W-1:0] cfg_data
);
  import nec_tx_pkg::*;

  nec_tx_cfg_t cfg_r;
  nec_tx_res_t res;
  logic        out_valid_r, out_valid_nxt;
  logic        accept;

  // Handshake: result register drains or is empty, so a request enters
  assign in_stall      = out_valid_r & out_stall;
  assign accept        = in_valid & ~in_stall;
  assign out_valid_nxt = accept | (out_valid_r & out_stall);
  assign cfg_ready     = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Timing registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.hdr_mark   <= HDR_MARK_RST;
      cfg_r.hdr_space  <= HDR_SPACE_RST;
      cfg_r.bit_mark   <= BIT_MARK_RST;
      cfg_r.one_space  <= ONE_SPACE_RST;
      cfg_r.zero_space <= ZERO_SPACE_RST;
      cfg_r.stop_mark  <= STOP_MARK_RST;
      cfg_r.gap        <= GAP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_HDR_MARK:   cfg_r.hdr_mark   <= cfg_data[DUR_W-1:0];
        CFG_HDR_SPACE:  cfg_r.hdr_space  <= cfg_data[DUR_W-1:0];
        CFG_BIT_MARK:   cfg_r.bit_mark   <= cfg_data[DUR_W-1:0];
        CFG_ONE_SPACE:  cfg_r.one_space  <= cfg_data[DUR_W-1:0];
        CFG_ZERO_SPACE: cfg_r.zero_space <= cfg_data[DUR_W-1:0];
        CFG_STOP_MARK:  cfg_r.stop_mark  <= cfg_data[DUR_W-1:0];
        CFG_GAP:        cfg_r.gap        <= cfg_data[GAP_TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  nec_tx_engine #(
    .GAP_COUNTER_BITS (GAP_COUNTER_BITS)
  ) u_engine (
    .clk             (clk),
    .rst_n           (rst_n),
    .step_en         (accept),
    .in_kind         (in_kind),
    .in_addr         (in_addr),
    .in_cmd          (in_cmd),
    .in_repeat_total (in_repeat_total),
    .cfg             (cfg_r),
    .res             (res)
  );

  assign out_valid         = out_valid_r;
  assign out_mark          = res.mark;
  assign out_tx_busy       = res.tx_busy;
  assign out_sequence_done = res.sequence_done;
  assign out_frame_start   = res.frame_start;

  // Every accepted request yields a result on the next cycle
  a_accept_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid)
    else $error("accepted request produced no result");

  // A result held under stall keeps its value
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> $stable(res))
    else $error("stalled result changed");

  // A result sitting under stall blocks the input side
  a_block_input: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |-> !accept)
    else $error("request accepted over a stalled result");

endmodule
